FILE: design/illsr_pkg.sv
// Shared request/response types and request codes for the linked-list swap/remove block.
package illsr_pkg;

   // Request codes (the unused code is ignored)
   localparam logic [1:0] REQ_APPEND   = 2'd0;
   localparam logic [1:0] REQ_OVERTAKE = 2'd1;
   localparam logic [1:0] REQ_DROPOUT  = 2'd2;
   localparam logic [1:0] REQ_UNUSED   = 2'd3;

   localparam int ID_WIDTH = 10;

   typedef struct packed {
      logic [1:0]          req_type;
      logic [ID_WIDTH-1:0] entry_id;
   } req_data_type;

   typedef struct packed {
      logic                status;
      logic [ID_WIDTH-1:0] passed_id;
      logic                passed_valid;
   } rsp_data_type;

endpackage

FILE: design/index_linked_list_swap_remove.sv
// Top level: doubly linked ordering of entry ids kept in previous and next link memories.
//
//  channel  | ports                        | handshake
//  ---------+------------------------------+-----------------------------------------
//  request  | start, busy, req_data        | taken at a clock edge with start & !busy
//  response | rsp_valid, rsp_data          | one-cycle strobe, receiver cannot stall
//
// States per request (busy high): ignored ST_RESP; append ST_WR_A, ST_WR_B; failed
// overtake ST_RD_LINKS, ST_RD_FWD; dropout adds ST_WR_A, ST_WR_B; overtake adds ST_WR_C;
// set by the two registered reads and the single write port of each link memory.
// Response strobe rises in the first cycle that busy is low again.
// After reset a clearing pass walks both link memories, one entry a cycle:
// busy stays high until every entry is cleared, before the first request is taken.
module index_linked_list_swap_remove
   import illsr_pkg::*;
#(
   parameter int MAX_ENTRIES = 1024
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_data_type req_data,
   output logic         rsp_valid,
   output rsp_data_type rsp_data
);

   localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam logic [IW-1:0] CLR_LAST = IW'(MAX_ENTRIES - 1);

   typedef struct packed {
      logic          valid;
      logic [IW-1:0] id;
   } link_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RD_LINKS,
      ST_RD_FWD,
      ST_WR_A,
      ST_WR_B,
      ST_WR_C,
      ST_RESP
   } state_type;

   state_type    state_ff;
   logic [IW-1:0] clr_ff;
   logic [IW-1:0] v_ff;
   logic [1:0]    op_ff;
   link_type      f_ff;
   link_type      b_ff;
   logic [IW-1:0] tail_ff;
   logic          tail_valid_ff;
   logic          rsp_valid_ff;
   rsp_data_type  rsp_data_ff;

   // Link memories and their registered read data
   link_type      prev_mem [MAX_ENTRIES];
   link_type      next_mem [MAX_ENTRIES];
   link_type      prev_rd_ff;
   link_type      next_rd_ff;

   logic          rd_en;
   logic [IW-1:0] prev_ra;
   logic          prev_we;
   logic [IW-1:0] prev_wa;
   link_type      prev_wd;
   logic          next_we;
   logic [IW-1:0] next_wa;
   link_type      next_wd;

   logic          accept;
   logic          in_range;
   link_type      v_link;

   assign accept   = start && (state_ff == ST_IDLE);
   assign in_range = 32'(req_data.entry_id) < 32'(MAX_ENTRIES);
   assign v_link   = '{valid: 1'b1, id: v_ff};

   // Read the entry's own links first, then the predecessor's previous link
   always_comb begin
      rd_en   = (state_ff == ST_RD_LINKS) || (state_ff == ST_RD_FWD);
      prev_ra = (state_ff == ST_RD_FWD) ? prev_rd_ff.id : v_ff;
   end

   // Select the write of each memory for the current step
   always_comb begin
      prev_we = 1'b0;
      prev_wa = v_ff;
      prev_wd = '0;
      next_we = 1'b0;
      next_wa = v_ff;
      next_wd = '0;
      case (state_ff)
         ST_CLEAR: begin
            prev_we = 1'b1;
            prev_wa = clr_ff;
            next_we = 1'b1;
            next_wa = clr_ff;
         end
         ST_WR_A: begin
            case (op_ff)
               REQ_APPEND: begin
                  next_we = tail_valid_ff;
                  next_wa = tail_ff;
                  next_wd = v_link;
                  prev_we = 1'b1;
                  prev_wa = v_ff;
                  prev_wd = tail_valid_ff ? link_type'{valid: 1'b1, id: tail_ff} : '0;
               end
               REQ_OVERTAKE: begin
                  prev_we = b_ff.valid;
                  prev_wa = b_ff.id;
                  prev_wd = f_ff;
                  next_we = prev_rd_ff.valid;
                  next_wa = prev_rd_ff.id;
                  next_wd = v_link;
               end
               REQ_DROPOUT: begin
                  prev_we = b_ff.valid;
                  prev_wa = b_ff.id;
                  prev_wd = f_ff;
                  next_we = f_ff.valid;
                  next_wa = f_ff.id;
                  next_wd = b_ff;
               end
               default: begin
               end
            endcase
         end
         ST_WR_B: begin
            case (op_ff)
               REQ_APPEND: begin
                  next_we = 1'b1;
                  next_wa = v_ff;
               end
               REQ_OVERTAKE: begin
                  prev_we = 1'b1;
                  prev_wa = v_ff;
                  prev_wd = prev_rd_ff;
                  next_we = 1'b1;
                  next_wa = f_ff.id;
                  next_wd = b_ff;
               end
               REQ_DROPOUT: begin
                  prev_we = 1'b1;
                  prev_wa = v_ff;
                  next_we = 1'b1;
                  next_wa = v_ff;
               end
               default: begin
               end
            endcase
         end
         ST_WR_C: begin
            prev_we = 1'b1;
            prev_wa = f_ff.id;
            prev_wd = v_link;
            next_we = 1'b1;
            next_wa = v_ff;
            next_wd = f_ff;
         end
         default: begin
         end
      endcase
   end

   // Previous-link memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (prev_we) begin
         prev_mem[prev_wa] <= prev_wd;
      end
      if (rd_en) begin
         prev_rd_ff <= prev_mem[prev_ra];
      end
   end

   // Next-link memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (next_we) begin
         next_mem[next_wa] <= next_wd;
      end
      if (rd_en) begin
         next_rd_ff <= next_mem[v_ff];
      end
   end

   // Sequencer, tail tracking and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         tail_ff       <= '0;
         tail_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         rsp_data_ff   <= '0;
         v_ff          <= '0;
         op_ff         <= REQ_APPEND;
         f_ff          <= '0;
         b_ff          <= '0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == CLR_LAST) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (start) begin
                  v_ff  <= IW'(req_data.entry_id);
                  op_ff <= req_data.req_type;
                  if (!in_range) begin
                     state_ff <= ST_RESP;
                  end else begin
                     case (req_data.req_type)
                        REQ_APPEND:   state_ff <= ST_WR_A;
                        REQ_OVERTAKE: state_ff <= ST_RD_LINKS;
                        REQ_DROPOUT:  state_ff <= ST_RD_LINKS;
                        default:      state_ff <= ST_RESP;
                     endcase
                  end
               end
            end
            ST_RD_LINKS: begin
               state_ff <= ST_RD_FWD;
            end
            ST_RD_FWD: begin
               f_ff <= prev_rd_ff;
               b_ff <= next_rd_ff;
               if (op_ff == REQ_OVERTAKE && !prev_rd_ff.valid) begin
                  // no predecessor: report the error and leave the list alone
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= '{status: 1'b1, passed_id: '0, passed_valid: 1'b0};
                  state_ff     <= ST_IDLE;
               end else begin
                  state_ff <= ST_WR_A;
               end
            end
            ST_WR_A: begin
               state_ff <= ST_WR_B;
            end
            ST_WR_B: begin
               if (op_ff == REQ_OVERTAKE) begin
                  state_ff <= ST_WR_C;
               end else begin
                  if (op_ff == REQ_APPEND) begin
                     tail_ff       <= v_ff;
                     tail_valid_ff <= 1'b1;
                  end else if (tail_valid_ff && tail_ff == v_ff) begin
                     // dropping the tail: predecessor takes over, or the list empties
                     if (f_ff.valid) begin
                        tail_ff <= f_ff.id;
                     end else begin
                        tail_ff       <= '0;
                        tail_valid_ff <= 1'b0;
                     end
                  end
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= '0;
                  state_ff     <= ST_IDLE;
               end
            end
            ST_WR_C: begin
               // overtaking the tail makes the passed entry the tail
               if (!b_ff.valid && tail_valid_ff && tail_ff == v_ff) begin
                  tail_ff <= f_ff.id;
               end
               rsp_valid_ff <= 1'b1;
               rsp_data_ff  <= '{status: 1'b0, passed_id: ID_WIDTH'(f_ff.id),
                                 passed_valid: 1'b1};
               state_ff     <= ST_IDLE;
            end
            ST_RESP: begin
               rsp_valid_ff <= 1'b1;
               rsp_data_ff  <= '0;
               state_ff     <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A taken request keeps the block busy in the next cycle with no response yet
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> (busy && !rsp_valid))
      else $error("request taken but block not busy or response too early");

   // A response only appears once the block is free again
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!busy && $past(busy)))
      else $error("response strobe outside end of request");

   // A failed overtake never reports a passed entry
   a_err_no_pass: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status) |-> (!rsp_data.passed_valid && rsp_data.passed_id == '0))
      else $error("error response carries a passed entry");

   // The clearing pass holds requests off right after reset
   a_clear_busy: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> busy)
      else $error("block free before clearing pass");

endmodule
